// ===== rtl/idll_pkg.sv =====
// shared types and constants of the indexed doubly linked list unit
// no dependencies; imported by the interfaces, controller, datapath and checker
package idll_pkg;

	localparam int CMD_W    = 3;
	localparam int ITEM_W   = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 3;
	localparam int FOUND_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FIRST,
		CMD_INS_LAST,
		CMD_INS_AT,
		CMD_DEL_FIRST,
		CMD_DEL_LAST,
		CMD_DEL_VALUE,
		CMD_SEARCH
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY,
		STAT_NOT_FOUND,
		STAT_BAD_POS,
		STAT_RANGE
	} status_t;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_HEAD,
		OP_STEP,
		OP_RD_FREE,
		OP_IF_LINK,
		OP_IF_FIX,
		OP_IA_LINK,
		OP_IA_FIX,
		OP_DF,
		OP_DL_UNLINK,
		OP_DV_UNLINK,
		OP_FREE_CUR,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_IF_LINK,
		S_IF_FIX,
		S_POS_WALK,
		S_TAIL_WALK,
		S_IA_LINK,
		S_IA_FIX,
		S_DF,
		S_FIND,
		S_FREE,
		S_DONE
	} state_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic pos_zero;
		logic pos_one;
		logic free_nil;
		logic head_nil;
		logic fwd_nil;
		logic match;
		logic walk_last;
		logic pos_hit;
	} dp_flags_t;

endpackage

// ===== rtl/idll_req_if.sv =====
// request channel of the list unit: command, value and insert position
// depends on idll_pkg for field widths
interface idll_req_if import idll_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [ITEM_W-1:0] item_value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output command, output item_value, output position,
		input ready);
	modport sink (input valid, input command, input item_value, input position,
		output ready);
endinterface

// ===== rtl/idll_rsp_if.sv =====
// response channel of the list unit: status and search position
// depends on idll_pkg for field widths
interface idll_rsp_if import idll_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [FOUND_W-1:0]    found_position;

	modport source (output valid, output status, output found_position, input ready);
	modport sink (input valid, input status, input found_position, output ready);
endinterface

// ===== rtl/idll_ctrl.sv =====
// controller state machine of the list unit: sequences datapath operations
// depends on idll_pkg; drives the request ready and response valid handshakes
module idll_ctrl import idll_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  dp_flags_t flags,
	output dp_cmd_t   cmd
);

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    out_valid_q;
	logic    res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		st_d       = st_q;
		cmd.op     = OP_NONE;
		cmd.status = st_q;
		req_ready  = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				st_d    = STAT_OK;
				state_d = S_DONE;
				unique case (flags.cmd) inside
					CMD_INS_FIRST: begin
						if (flags.free_nil) begin
							st_d = STAT_FULL;
						end else begin
							cmd.op  = OP_RD_FREE;
							state_d = S_IF_LINK;
						end
					end
					CMD_INS_LAST: begin
						if (flags.free_nil) begin
							st_d = STAT_FULL;
						end else if (flags.head_nil) begin
							cmd.op  = OP_RD_FREE;
							state_d = S_IF_LINK;
						end else begin
							cmd.op  = OP_RD_HEAD;
							state_d = S_TAIL_WALK;
						end
					end
					CMD_INS_AT: begin
						if (flags.pos_zero) begin
							st_d = STAT_BAD_POS;
						end else if (flags.free_nil) begin
							st_d = STAT_FULL;
						end else if (flags.pos_one) begin
							cmd.op  = OP_RD_FREE;
							state_d = S_IF_LINK;
						end else if (flags.head_nil) begin
							st_d = STAT_RANGE;
						end else begin
							cmd.op  = OP_RD_HEAD;
							state_d = S_POS_WALK;
						end
					end
					CMD_DEL_FIRST: begin
						if (flags.head_nil) begin
							st_d = STAT_EMPTY;
						end else begin
							cmd.op  = OP_RD_HEAD;
							state_d = S_DF;
						end
					end
					CMD_DEL_LAST: begin
						if (flags.head_nil) begin
							st_d = STAT_EMPTY;
						end else begin
							cmd.op  = OP_RD_HEAD;
							state_d = S_TAIL_WALK;
						end
					end
					CMD_DEL_VALUE, CMD_SEARCH: begin
						if (flags.head_nil) begin
							st_d = STAT_NOT_FOUND;
						end else begin
							cmd.op  = OP_RD_HEAD;
							state_d = S_FIND;
						end
					end
					default: begin
						st_d = STAT_OK;
					end
				endcase
			end
			S_IF_LINK: begin
				cmd.op  = OP_IF_LINK;
				state_d = S_IF_FIX;
			end
			S_IF_FIX: begin
				cmd.op  = OP_IF_FIX;
				state_d = S_DONE;
			end
			S_POS_WALK: begin
				if (flags.pos_hit) begin
					cmd.op  = OP_RD_FREE;
					state_d = S_IA_LINK;
				end else if (flags.fwd_nil) begin
					st_d    = STAT_RANGE;
					state_d = S_DONE;
				end else begin
					cmd.op = OP_STEP;
				end
			end
			S_TAIL_WALK: begin
				if (flags.fwd_nil || flags.walk_last) begin
					if (flags.cmd == CMD_DEL_LAST) begin
						cmd.op  = OP_DL_UNLINK;
						state_d = S_FREE;
					end else begin
						cmd.op  = OP_RD_FREE;
						state_d = S_IA_LINK;
					end
				end else begin
					cmd.op = OP_STEP;
				end
			end
			S_IA_LINK: begin
				cmd.op  = OP_IA_LINK;
				state_d = S_IA_FIX;
			end
			S_IA_FIX: begin
				cmd.op  = OP_IA_FIX;
				state_d = S_DONE;
			end
			S_DF: begin
				cmd.op  = OP_DF;
				state_d = S_DONE;
			end
			S_FIND: begin
				if (flags.match) begin
					if (flags.cmd == CMD_SEARCH) begin
						state_d = S_DONE;
					end else begin
						cmd.op  = OP_DV_UNLINK;
						state_d = S_FREE;
					end
				end else if (flags.fwd_nil || flags.walk_last) begin
					st_d    = STAT_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					cmd.op = OP_STEP;
				end
			end
			S_FREE: begin
				cmd.op  = OP_FREE_CUR;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.op   = OP_RESULT;
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/idll_datapath.sv =====
// datapath of the list unit: slot stores, link registers, walk pointer, result
// depends on idll_pkg; driven by operations from idll_ctrl
module idll_datapath import idll_pkg::*; #(
	parameter int SLOT_COUNT  = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [ITEM_W-1:0] item_value,
	input  logic [POS_W-1:0]         position,
	input  dp_cmd_t                  cmd,
	output dp_flags_t                flags,
	output logic [STATUS_W-1:0]      status,
	output logic [FOUND_W-1:0]       found_position
);

	localparam int AW   = $clog2(SLOT_COUNT);
	localparam int LW   = $clog2(SLOT_COUNT + 1);
	localparam int CMPW = ((LW > POS_W) ? LW : POS_W) + 1;
	localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);

	// slot stores
	logic [VALUE_WIDTH-1:0] val_mem [SLOT_COUNT];
	logic [LW-1:0]          fwd_mem [SLOT_COUNT];
	logic [LW-1:0]          bwd_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]  fwd_vld_q;
	logic [SLOT_COUNT-1:0]  bwd_vld_q;

	// registered read port
	logic [AW-1:0]          ra_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;
	logic [LW-1:0]          fwd_rd_q;
	logic [LW-1:0]          bwd_rd_q;
	logic                   fwd_rv_q;
	logic                   bwd_rv_q;

	logic [LW-1:0]          head_q, free_q, cur_q, new_q, nx_q, cnt_q;
	cmd_t                   cmd_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [POS_W-1:0]       pos_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [FOUND_W-1:0]     res_found_q;

	logic [LW-1:0]          rd_fwd, rd_bwd, ra;
	logic                   fwd_we, bwd_we, val_we;
	logic [LW-1:0]          fwd_wa, fwd_wd, bwd_wa, bwd_wd;

	// entries never written read as their reset links
	assign rd_fwd = fwd_rv_q ? fwd_rd_q : (LW'(ra_q) + LW'(1));
	assign rd_bwd = bwd_rv_q ? bwd_rd_q : NIL;

	always_comb begin
		ra     = cur_q;
		fwd_we = 1'b0;
		fwd_wa = cur_q;
		fwd_wd = NIL;
		bwd_we = 1'b0;
		bwd_wa = cur_q;
		bwd_wd = NIL;
		val_we = 1'b0;
		unique case (cmd.op)
			OP_RD_HEAD: ra = head_q;
			OP_STEP:    ra = rd_fwd;
			OP_RD_FREE: ra = free_q;
			OP_IF_LINK: begin
				val_we = 1'b1;
				fwd_we = 1'b1;
				fwd_wa = new_q;
				fwd_wd = head_q;
				bwd_we = 1'b1;
				bwd_wa = new_q;
				bwd_wd = NIL;
			end
			OP_IF_FIX: begin
				bwd_we = (head_q != NIL);
				bwd_wa = head_q;
				bwd_wd = new_q;
			end
			OP_IA_LINK: begin
				val_we = 1'b1;
				fwd_we = 1'b1;
				fwd_wa = new_q;
				fwd_wd = nx_q;
				bwd_we = 1'b1;
				bwd_wa = new_q;
				bwd_wd = cur_q;
			end
			OP_IA_FIX: begin
				bwd_we = (nx_q != NIL);
				bwd_wa = nx_q;
				bwd_wd = new_q;
				fwd_we = 1'b1;
				fwd_wa = cur_q;
				fwd_wd = new_q;
			end
			OP_DF: begin
				bwd_we = (rd_fwd != NIL);
				bwd_wa = rd_fwd;
				bwd_wd = NIL;
				fwd_we = 1'b1;
				fwd_wa = cur_q;
				fwd_wd = free_q;
			end
			OP_DL_UNLINK: begin
				fwd_we = (rd_bwd != NIL);
				fwd_wa = rd_bwd;
				fwd_wd = NIL;
			end
			OP_DV_UNLINK: begin
				fwd_we = (rd_bwd != NIL);
				fwd_wa = rd_bwd;
				fwd_wd = rd_fwd;
				bwd_we = (rd_fwd != NIL);
				bwd_wa = rd_fwd;
				bwd_wd = rd_bwd;
			end
			OP_FREE_CUR: begin
				fwd_we = 1'b1;
				fwd_wa = cur_q;
				fwd_wd = free_q;
			end
			default: begin
				ra = cur_q;
			end
		endcase
	end

	// memories, read-old on a same-address write
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[new_q[AW-1:0]] <= val_q;
		end
		if (fwd_we) begin
			fwd_mem[fwd_wa[AW-1:0]] <= fwd_wd;
		end
		if (bwd_we) begin
			bwd_mem[bwd_wa[AW-1:0]] <= bwd_wd;
		end
		ra_q     <= ra[AW-1:0];
		val_rd_q <= val_mem[ra[AW-1:0]];
		fwd_rd_q <= fwd_mem[ra[AW-1:0]];
		bwd_rd_q <= bwd_mem[ra[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= '0;
			bwd_vld_q <= '0;
			fwd_rv_q  <= 1'b0;
			bwd_rv_q  <= 1'b0;
			head_q    <= NIL;
			free_q    <= '0;
			cur_q     <= NIL;
			cnt_q     <= '0;
			cmd_q     <= CMD_INS_FIRST;
		end else begin
			if (fwd_we) begin
				fwd_vld_q[fwd_wa[AW-1:0]] <= 1'b1;
			end
			if (bwd_we) begin
				bwd_vld_q[bwd_wa[AW-1:0]] <= 1'b1;
			end
			fwd_rv_q <= fwd_vld_q[ra[AW-1:0]];
			bwd_rv_q <= bwd_vld_q[ra[AW-1:0]];
			case (cmd.op) inside
				OP_LOAD: cmd_q <= cmd_t'(command);
				OP_RD_HEAD: begin
					cur_q <= head_q;
					cnt_q <= '0;
				end
				OP_STEP: begin
					cur_q <= rd_fwd;
					cnt_q <= cnt_q + LW'(1);
				end
				OP_IF_LINK, OP_IA_LINK: free_q <= rd_fwd;
				OP_IF_FIX: head_q <= new_q;
				OP_DF: begin
					head_q <= rd_fwd;
					free_q <= cur_q;
				end
				OP_DL_UNLINK: begin
					if (rd_bwd == NIL) begin
						head_q <= NIL;
					end
				end
				OP_DV_UNLINK: begin
					if (rd_bwd == NIL) begin
						head_q <= rd_fwd;
					end
				end
				OP_FREE_CUR: free_q <= cur_q;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				val_q <= VALUE_WIDTH'(item_value);
				pos_q <= position;
			end
			OP_RD_FREE: begin
				new_q <= free_q;
				nx_q  <= rd_fwd;
			end
			OP_RESULT: begin
				res_status_q <= cmd.status;
				if (cmd.status == STAT_OK && cmd_q == CMD_SEARCH) begin
					res_found_q <= FOUND_W'(cnt_q + LW'(1));
				end else begin
					res_found_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign status         = res_status_q;
	assign found_position = res_found_q;

	always_comb begin
		flags.cmd       = cmd_q;
		flags.pos_zero  = (pos_q == '0);
		flags.pos_one   = (pos_q == POS_W'(1));
		flags.free_nil  = (free_q == NIL);
		flags.head_nil  = (head_q == NIL);
		flags.fwd_nil   = (rd_fwd == NIL);
		flags.match     = (val_rd_q == val_q);
		flags.walk_last = (cnt_q == LW'(SLOT_COUNT - 1));
		flags.pos_hit   = ((CMPW'(cnt_q) + CMPW'(2)) == CMPW'(pos_q));
	end

endmodule

// ===== rtl/indexed_doubly_linked_list_unit.sv =====
// indexed doubly linked list unit: 7 commands over a slot store with a free list
// a command that fails its first check goes from decode straight to done; insert last,
// insert at, delete last, delete value and search may first walk the list; walks follow
// one link per cycle through the slot read port; the response turns valid with the next ready
// throughput: one command at a time, a stalled response holds the next one in the done state
// reset: asynchronous active low; list empty, free list 0..SLOT_COUNT-1, no clearing pass
module indexed_doubly_linked_list_unit import idll_pkg::*; #(
	parameter int SLOT_COUNT  = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	idll_req_if.sink   req,
	idll_rsp_if.source rsp
);

	// command and status between controller and datapath
	dp_cmd_t   dp_cmd;
	dp_flags_t dp_flags;

	// controller: handshakes and the sequence of datapath operations
	idll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.flags     (dp_flags),
		.cmd       (dp_cmd)
	);

	// datapath: slot values, forward and backward links, head and free pointers,
	// the walk pointer and the result register that holds the response payload
	idll_datapath #(
		.SLOT_COUNT  (SLOT_COUNT),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (req.command),
		.item_value     (req.item_value),
		.position       (req.position),
		.cmd            (dp_cmd),
		.flags          (dp_flags),
		.status         (rsp.status),
		.found_position (rsp.found_position)
	);

endmodule

// ===== rtl/idll_checker.sv =====
// port-level checks of the list unit, bound to the top level
// depends on idll_pkg and indexed_doubly_linked_list_unit
module idll_checker import idll_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [FOUND_W-1:0]  found_position
);

	logic [1:0] pending_q;
	logic       req_xfer, rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// commands taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_xfer && !req_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without a pending command");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two commands outstanding");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found_position != '0 |-> status == STAT_OK)
		else $error("search position with a failing status");

	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(found_position) <= 32'(SLOT_COUNT))
		else $error("search position beyond the slot count");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found_position))
		else $error("stalled response changed");

endmodule

bind indexed_doubly_linked_list_unit idll_checker #(
	.SLOT_COUNT (SLOT_COUNT)
) u_idll_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.found_position (rsp.found_position)
);

// ===== bench/indexed_doubly_linked_list_unit_tb.sv =====
// self-checking testbench of the indexed doubly linked list unit
// drives the request channel and checks every reply against a model kept in the bench or a directed table
// depends on idll_pkg, idll_req_if, idll_rsp_if and the unit itself
`timescale 1ns / 1ps

module indexed_doubly_linked_list_unit_tb;
	import idll_pkg::*;

	localparam int SLOT_COUNT  = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int LINK_W      = $clog2(SLOT_COUNT + 1);
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 80;
	localparam int HOLD_CYCLES = 150;
	// worst command is a full walk plus its update steps
	localparam int DRAIN_CYCLES = SLOT_COUNT + 24;

	// command code outside the enum, answered with ok and no change
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	// stimulus shaping modes of the random part
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	localparam logic TYPED = 1'b1;
	localparam logic PRED  = 1'b0;

	localparam logic signed [ITEM_W-1:0] MAX_VAL = 32'sh7fffffff;
	localparam logic signed [ITEM_W-1:0] MIN_VAL = 32'sh80000000;

	typedef logic [LINK_W-1:0]      link_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;

	localparam link_t NIL = link_t'(SLOT_COUNT);

	typedef struct packed {
		status_t              status;
		logic [FOUND_W-1:0]   found;
	} reply_t;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [ITEM_W-1:0] value;
		logic [POS_W-1:0]         pos;
		logic                     typed;
		status_t                  status;
		logic [FOUND_W-1:0]       found;
	} dir_row_t;

	localparam int DIR_ROWS = 23;

	// directed table: empty-list errors first, then a small list built and torn down
	dir_row_t directed_rows [0:DIR_ROWS-1] = '{
		'{CMD_DEL_FIRST, 32'sd0,  8'd0,   TYPED, STAT_EMPTY,     5'd0},
		'{CMD_DEL_LAST,  32'sd0,  8'd0,   TYPED, STAT_EMPTY,     5'd0},
		'{CMD_SEARCH,    32'sd0,  8'd0,   TYPED, STAT_NOT_FOUND, 5'd0},
		'{CMD_DEL_VALUE, 32'sd0,  8'd0,   TYPED, STAT_NOT_FOUND, 5'd0},
		'{CMD_INS_AT,    32'sd9,  8'd0,   TYPED, STAT_BAD_POS,   5'd0},
		'{CMD_INS_AT,    32'sd9,  8'd2,   TYPED, STAT_RANGE,     5'd0},
		'{CMD_INS_AT,    32'sd9,  8'd255, TYPED, STAT_RANGE,     5'd0},
		'{CMD_UNUSED,    -32'sd1, 8'd255, TYPED, STAT_OK,        5'd0},
		'{CMD_INS_FIRST, MAX_VAL, 8'd0,   TYPED, STAT_OK,        5'd0},
		'{CMD_INS_LAST,  MIN_VAL, 8'd0,   TYPED, STAT_OK,        5'd0},
		'{CMD_INS_AT,    -32'sd1, 8'd1,   TYPED, STAT_OK,        5'd0},
		'{CMD_INS_AT,    32'sd0,  8'd4,   TYPED, STAT_OK,        5'd0},
		'{CMD_SEARCH,    -32'sd1, 8'd0,   TYPED, STAT_OK,        5'd1},
		'{CMD_SEARCH,    MIN_VAL, 8'd0,   PRED,  STAT_OK,        5'd0},
		'{CMD_SEARCH,    32'sd5,  8'd0,   TYPED, STAT_NOT_FOUND, 5'd0},
		'{CMD_INS_AT,    32'sd5,  8'd6,   TYPED, STAT_RANGE,     5'd0},
		'{CMD_INS_AT,    32'sd5,  8'd5,   PRED,  STAT_OK,        5'd0},
		'{CMD_DEL_VALUE, MIN_VAL, 8'd0,   PRED,  STAT_OK,        5'd0},
		'{CMD_DEL_VALUE, MAX_VAL, 8'd0,   PRED,  STAT_OK,        5'd0},
		'{CMD_DEL_LAST,  32'sd0,  8'd0,   PRED,  STAT_OK,        5'd0},
		'{CMD_DEL_FIRST, 32'sd0,  8'd0,   PRED,  STAT_OK,        5'd0},
		'{CMD_DEL_FIRST, 32'sd0,  8'd0,   PRED,  STAT_OK,        5'd0},
		'{CMD_DEL_LAST,  32'sd0,  8'd0,   TYPED, STAT_EMPTY,     5'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	idll_req_if req_ch ();
	idll_rsp_if rsp_ch ();

	indexed_doubly_linked_list_unit #(
		.SLOT_COUNT (SLOT_COUNT),
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #6 clk = ~clk;

	// bench copy of the list state
	value_t slot_vals [SLOT_COUNT];
	link_t  fwd_link  [SLOT_COUNT];
	link_t  bwd_link  [SLOT_COUNT];
	link_t  head_slot;
	link_t  free_slot_head;

	reply_t awaited_replies [$];

	int  failures      = 0;
	int  issued        = 0;
	int  replies_seen  = 0;
	int  full_hits     = 0;
	int  empty_hits    = 0;
	bit  idle_on       = 1'b0;
	bit  hold_request  = 1'b0;

	// ---------------------------------------------------------------
	// list model
	// ---------------------------------------------------------------

	function automatic void reset_list();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			fwd_link[i] = link_t'(i + 1);
			bwd_link[i] = NIL;
		end
		head_slot      = NIL;
		free_slot_head = '0;
	endfunction

	// a null link stays null
	function automatic link_t next_link(link_t s);
		return (s < NIL) ? fwd_link[s] : NIL;
	endfunction

	// pop the free-list head and store the value there
	function automatic link_t take_slot(value_t v);
		link_t s;
		s = free_slot_head;
		free_slot_head = next_link(s);
		slot_vals[s] = v;
		return s;
	endfunction

	// freed slot keeps its old backward link, only the forward link joins the free list
	function automatic void release_slot(link_t s);
		fwd_link[s]    = free_slot_head;
		free_slot_head = s;
	endfunction

	function automatic link_t tail_slot();
		link_t t;
		t = head_slot;
		for (int k = 0; k < SLOT_COUNT && next_link(t) != NIL; k++)
			t = next_link(t);
		return t;
	endfunction

	// first node holding v, with its 1-based position (0 when missing)
	function automatic link_t find_slot(value_t v, output int p);
		link_t t;
		t = head_slot;
		p = 0;
		for (int k = 0; k < SLOT_COUNT && t != NIL; k++) begin
			if (slot_vals[t] == v) begin
				p = k + 1;
				return t;
			end
			t = next_link(t);
		end
		return NIL;
	endfunction

	function automatic status_t push_front(value_t v);
		link_t s;
		if (free_slot_head == NIL)
			return STAT_FULL;
		s = take_slot(v);
		bwd_link[s] = NIL;
		fwd_link[s] = head_slot;
		if (head_slot != NIL)
			bwd_link[head_slot] = s;
		head_slot = s;
		return STAT_OK;
	endfunction

	// apply one command to the bench list and return the reply it must produce
	function automatic reply_t apply_list_cmd(logic [CMD_W-1:0] cmd,
			logic signed [ITEM_W-1:0] item, logic [POS_W-1:0] pos);
		reply_t r;
		value_t v;
		link_t  s;
		link_t  t;
		int     p;
		r.status = STAT_OK;
		r.found  = '0;
		// sign-extend, then keep the store width
		v = value_t'(item);
		case (cmd)
			CMD_INS_FIRST: r.status = push_front(v);
			CMD_INS_LAST: begin
				if (free_slot_head == NIL) begin
					r.status = STAT_FULL;
				end else if (head_slot == NIL) begin
					s = take_slot(v);
					fwd_link[s] = NIL;
					bwd_link[s] = NIL;
					head_slot   = s;
				end else begin
					t = tail_slot();
					s = take_slot(v);
					fwd_link[s] = NIL;
					fwd_link[t] = s;
					bwd_link[s] = t;
				end
			end
			CMD_INS_AT: begin
				if (pos == 0) begin
					r.status = STAT_BAD_POS;
				end else if (pos == 1) begin
					r.status = push_front(v);
				end else if (free_slot_head == NIL) begin
					r.status = STAT_FULL;
				end else begin
					t = head_slot;
					for (int k = 1; k < int'(pos) - 1 && t != NIL; k++)
						t = next_link(t);
					if (t == NIL) begin
						r.status = STAT_RANGE;
					end else begin
						s = take_slot(v);
						fwd_link[s] = fwd_link[t];
						bwd_link[s] = t;
						if (fwd_link[t] != NIL)
							bwd_link[fwd_link[t]] = s;
						fwd_link[t] = s;
					end
				end
			end
			CMD_DEL_FIRST: begin
				if (head_slot == NIL) begin
					r.status = STAT_EMPTY;
				end else begin
					t = head_slot;
					head_slot = fwd_link[t];
					if (head_slot != NIL)
						bwd_link[head_slot] = NIL;
					release_slot(t);
				end
			end
			CMD_DEL_LAST: begin
				if (head_slot == NIL) begin
					r.status = STAT_EMPTY;
				end else begin
					t = tail_slot();
					if (bwd_link[t] != NIL)
						fwd_link[bwd_link[t]] = NIL;
					else
						head_slot = NIL;
					release_slot(t);
				end
			end
			CMD_DEL_VALUE: begin
				t = find_slot(v, p);
				if (t == NIL) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					if (bwd_link[t] != NIL)
						fwd_link[bwd_link[t]] = fwd_link[t];
					else
						head_slot = fwd_link[t];
					if (fwd_link[t] != NIL)
						bwd_link[fwd_link[t]] = bwd_link[t];
					release_slot(t);
				end
			end
			CMD_SEARCH: begin
				t = find_slot(v, p);
				if (t == NIL)
					r.status = STAT_NOT_FOUND;
				else
					r.found = FOUND_W'(p);
			end
			default: begin
				// unused code: nothing changes
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------

	// one request transfer; the reply is predicted at the accepting edge
	task automatic send_command(input logic [CMD_W-1:0] cmd,
			input logic signed [ITEM_W-1:0] item, input logic [POS_W-1:0] pos,
			input logic typed, input reply_t typed_reply);
		int     gap;
		reply_t r;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.command    <= cmd;
		req_ch.item_value <= item;
		req_ch.position   <= pos;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		r = apply_list_cmd(cmd, item, pos);
		if (r.status == STAT_FULL)
			full_hits++;
		if (r.status == STAT_EMPTY)
			empty_hits++;
		awaited_replies.push_back(typed ? typed_reply : r);
		issued++;
	endtask

	// random command code between two codes
	function automatic logic [CMD_W-1:0] CMD_CMD(int lo, int hi);
		return CMD_W'($urandom_range(lo, hi));
	endfunction

	// random command shaped by the current mode; values are often taken from the list
	// so that searches and value deletes hit
	task automatic random_command(input int mode);
		logic [CMD_W-1:0]         cmd;
		logic signed [ITEM_W-1:0] item;
		logic [POS_W-1:0]         pos;
		int                       len;
		int                       pick;
		int                       roll;
		link_t                    t;
		len = 0;
		t = head_slot;
		while (t != NIL && len < SLOT_COUNT) begin
			len++;
			t = next_link(t);
		end
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:
				cmd = (roll < 75) ? CMD_CMD(0, 2) : CMD_CMD(3, 6);
			MODE_DRAIN:
				cmd = (roll < 60) ? CMD_CMD(3, 5) : (roll < 80) ? CMD_SEARCH : CMD_CMD(0, 2);
			MODE_MIXED:
				cmd = (roll < 2) ? CMD_UNUSED : CMD_CMD(0, 6);
			default:
				cmd = CMD_UNUSED;
		endcase
		// value
		roll = $urandom_range(0, 99);
		if (roll < 55 && len > 0) begin
			pick = $urandom_range(0, len - 1);
			t = head_slot;
			repeat (pick) t = next_link(t);
			item = ITEM_W'(slot_vals[t]);
		end else if (roll < 80) begin
			case ($urandom_range(0, 5))
				0: item = 32'sd0;
				1: item = -32'sd1;
				2: item = 32'sd1;
				3: item = MIN_VAL;
				4: item = MAX_VAL;
				default: item = ITEM_W'($urandom_range(0, 7));
			endcase
		end else begin
			item = $urandom;
		end
		// position: mostly in range, some past the end, some zero, some anywhere
		roll = $urandom_range(0, 99);
		if (roll < 80)
			pos = POS_W'($urandom_range(1, len + 1));
		else if (roll < 90)
			pos = POS_W'($urandom_range(len + 2, 255));
		else if (roll < 95)
			pos = '0;
		else
			pos = POS_W'($urandom_range(0, 255));
		send_command(cmd, item, pos, PRED, '0);
	endtask

	// ---------------------------------------------------------------
	// reply side: ready with random stall bursts and one long hold-off
	// ---------------------------------------------------------------

	initial begin
		int stall_left;
		int hold_left;
		stall_left   = 0;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				// long hold-off while the sender keeps offering
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left   = $urandom_range(1, 4) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// each reply transfer is checked against the oldest awaited reply
	always @(posedge clk) begin
		reply_t exp_reply;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (awaited_replies.size() == 0) begin
				$error("reply with none awaited: status %0d found_position %0d",
					rsp_ch.status, rsp_ch.found_position);
				failures++;
			end else begin
				exp_reply = awaited_replies.pop_front();
				replies_seen++;
				if (rsp_ch.status !== exp_reply.status) begin
					$error("status: expected %0d, actual %0d",
						exp_reply.status, rsp_ch.status);
					failures++;
				end
				if (rsp_ch.found_position !== exp_reply.found) begin
					$error("found_position: expected %0d, actual %0d",
						exp_reply.found, rsp_ch.found_position);
					failures++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		int mode;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.command    = '0;
		req_ch.item_value = '0;
		req_ch.position   = '0;
		reset_list();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, no idling
		for (int i = 0; i < DIR_ROWS; i++)
			send_command(directed_rows[i].cmd, directed_rows[i].value,
				directed_rows[i].pos, directed_rows[i].typed,
				'{directed_rows[i].status, directed_rows[i].found});

		// random phases: fill, drain and mixed traffic in turn
		for (int ph = 0; ph < PHASES; ph++) begin
			mode = ph % 3;
			// first phase and the last one run without idling
			idle_on = (ph != 0) && (ph != PHASES - 1);
			if (ph == 2)
				hold_request = 1'b1;
			if (ph == 4) begin
				// sender pauses until every reply is back
				@(negedge clk);
				req_ch.valid <= 1'b0;
				while (awaited_replies.size() != 0) @(posedge clk);
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_command(mode);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands over fill, drain and mixed traffic, %0d replies checked",
			issued, replies_seen);
		$display("list reported full %0d times and empty %0d times", full_hits, empty_hits);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
